// ===== rtl/core/mlt_pkg.sv =====
// ----------------------------------------------------------------------------
// mlt_pkg: shared types and constants of the MAC learning table
// Outcome codes, table entry layout and parameter defaults.
// ----------------------------------------------------------------------------
package mlt_pkg;

  localparam int unsigned TableEntriesDefault = 1024;
  localparam int unsigned PortCountDefault    = 64;

  localparam int unsigned MacW    = 48;
  localparam int unsigned PortW   = 6;
  localparam int unsigned AgingW  = 20;
  localparam int unsigned SecW    = 32;
  localparam int unsigned OutW    = 3;

  localparam logic [AgingW-1:0] AgingReset = 20'd300;

  localparam logic ModeLearn = 1'b0;
  localparam logic ModeTick  = 1'b1;

  localparam logic [OutW-1:0] OutNew      = 3'd0;
  localparam logic [OutW-1:0] OutRefresh  = 3'd1;
  localparam logic [OutW-1:0] OutMoved    = 3'd2;
  localparam logic [OutW-1:0] OutLearnOff = 3'd3;
  localparam logic [OutW-1:0] OutFull     = 3'd4;
  localparam logic [OutW-1:0] OutTick     = 3'd5;
  localparam logic [OutW-1:0] OutSweep    = 3'd6;

  typedef struct packed {
    logic            valid;
    logic [MacW-1:0] mac;
    logic [PortW-1:0] port;
    logic [SecW-1:0] expiry;
  } entry_t;

endpackage

// ===== rtl/core/mlt_ram.sv =====
// ----------------------------------------------------------------------------
// mlt_ram: table entry memory
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module mlt_ram import mlt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDefault,
  localparam int unsigned AddrW = $clog2(TABLE_ENTRIES)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/core/mac_learning_table_with_aging.sv =====
// ----------------------------------------------------------------------------
// mac_learning_table_with_aging: bridge MAC learning table with aging sweep
// Learns source MACs into a table walked one entry at a time by a small
// sequencer; a periodic sweep removes expired entries.
// ----------------------------------------------------------------------------
//
//  channel   | signals                                         | direction
//  ----------+-------------------------------------------------+----------
//  command   | start_i, busy_o, mode_i, mac_addr_i, port_i,    | in
//            | learning_allowed_i                              |
//  result    | done_o, outcome_o, old_port_o, removed_count_o, | out
//            | entries_in_use_o, discard_total_o               |
//  config    | cfg_we_i, cfg_wdata_i (aging_time)              | in
//
//  A transaction is taken when start_i is high and busy_o is low.
//  Tick without sweep and learning off: result in the cycle after acceptance.
//  Learn: each entry visited passes through a memory read state, then a
//  compare state; the walk ends early on a hit, else visits every entry.
//  Sweep tick: every entry passes through the same read/compare loop.
//  After reset a clearing pass over all entries holds busy_o high.
//  done_o is high for exactly one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module mac_learning_table_with_aging import mlt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDefault,
  parameter int unsigned PORT_COUNT    = PortCountDefault,
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              mode_i,
  input  logic [MacW-1:0]   mac_addr_i,
  input  logic [PortW-1:0]  port_i,
  input  logic              learning_allowed_i,
  input  logic              cfg_we_i,
  input  logic [AgingW-1:0] cfg_wdata_i,
  output logic              done_o,
  output logic [OutW-1:0]   outcome_o,
  output logic [PortW-1:0]  old_port_o,
  output logic [CntW-1:0]   removed_count_o,
  output logic [CntW-1:0]   entries_in_use_o,
  output logic [SecW-1:0]   discard_total_o
);

  localparam int unsigned AddrW = $clog2(TABLE_ENTRIES);
  localparam logic [AddrW-1:0] LastIdx = AddrW'(TABLE_ENTRIES - 1);

  localparam logic [1:0] StClear = 2'd0;
  localparam logic [1:0] StIdle  = 2'd1;
  localparam logic [1:0] StRead  = 2'd2;
  localparam logic [1:0] StEval  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic [AddrW-1:0]  free_idx_q, free_idx_d;
  logic              free_found_q, free_found_d;
  logic              sweep_q, sweep_d;
  logic [CntW-1:0]   removed_q, removed_d;
  logic [CntW-1:0]   valid_cnt_q, valid_cnt_d;
  logic [SecW-1:0]   discard_q, discard_d;
  logic [SecW-1:0]   seconds_q, seconds_d;
  logic [AgingW-1:0] countdown_q, countdown_d;
  logic [AgingW-1:0] aging_q;
  logic [MacW-1:0]   mac_q, mac_d;
  logic [PortW-1:0]  port_q, port_d;

  logic              done_d;
  logic [OutW-1:0]   outcome_d;
  logic [PortW-1:0]  old_port_d;
  logic [CntW-1:0]   removed_out_d;

  logic              ram_we, ram_re;
  logic [AddrW-1:0]  ram_waddr;
  entry_t            ram_wdata, ram_rdata;

  logic [SecW-1:0]   expiry_new;
  logic              is_last, hit, expired;
  logic [CntW-1:0]   removed_inc;

  mlt_ram #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign busy_o      = (state_q != StIdle);
  assign expiry_new  = seconds_q + SecW'(aging_q);
  assign is_last     = (idx_q == LastIdx);
  assign hit         = ram_rdata.valid && (ram_rdata.mac == mac_q);
  assign expired     = ram_rdata.valid && (ram_rdata.expiry <= seconds_q);
  assign removed_inc = removed_q + CntW'(expired);

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    free_idx_d    = free_idx_q;
    free_found_d  = free_found_q;
    sweep_d       = sweep_q;
    removed_d     = removed_q;
    valid_cnt_d   = valid_cnt_q;
    discard_d     = discard_q;
    seconds_d     = seconds_q;
    countdown_d   = countdown_q;
    mac_d         = mac_q;
    port_d        = port_q;
    done_d        = 1'b0;
    outcome_d     = outcome_o;
    old_port_d    = old_port_o;
    removed_out_d = '0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = idx_q;
    ram_wdata     = '0;

    case (state_q)
      StClear: begin
        // Invalidate one entry per cycle after reset.
        ram_we = 1'b1;
        if (is_last) begin
          state_d = StIdle;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + AddrW'(1);
        end
      end

      StIdle: begin
        if (start_i) begin
          mac_d        = mac_addr_i;
          port_d       = port_i;
          idx_d        = '0;
          free_found_d = 1'b0;
          removed_d    = '0;
          if (mode_i == ModeTick) begin
            seconds_d = seconds_q + SecW'(1);
            if (countdown_q <= AgingW'(1)) begin
              // Reload the interval and start the sweep.
              countdown_d = (aging_q == '0) ? AgingW'(1) : aging_q;
              sweep_d     = 1'b1;
              state_d     = StRead;
            end else begin
              countdown_d = countdown_q - AgingW'(1);
              done_d      = 1'b1;
              outcome_d   = OutTick;
              old_port_d  = '0;
            end
          end else if (!learning_allowed_i ||
                       ({1'b0, port_i} >= (PortW+1)'(PORT_COUNT > 64 ? 64 : PORT_COUNT))) begin
            done_d     = 1'b1;
            outcome_d  = OutLearnOff;
            old_port_d = port_i;
          end else begin
            sweep_d = 1'b0;
            state_d = StRead;
          end
        end
      end

      StRead: begin
        ram_re  = 1'b1;
        state_d = StEval;
      end

      StEval: begin
        state_d = StRead;
        idx_d   = idx_q + AddrW'(1);
        if (sweep_q) begin
          if (expired) begin
            ram_we          = 1'b1;
            ram_wdata       = ram_rdata;
            ram_wdata.valid = 1'b0;
          end
          removed_d = removed_inc;
          if (is_last) begin
            state_d       = StIdle;
            valid_cnt_d   = valid_cnt_q - removed_inc;
            done_d        = 1'b1;
            outcome_d     = OutSweep;
            old_port_d    = '0;
            removed_out_d = removed_inc;
          end
        end else if (hit) begin
          // Known station: refresh expiry, follow a move.
          ram_we     = 1'b1;
          ram_wdata  = '{valid: 1'b1, mac: mac_q, port: port_q, expiry: expiry_new};
          state_d    = StIdle;
          done_d     = 1'b1;
          outcome_d  = (ram_rdata.port != port_q) ? OutMoved : OutRefresh;
          old_port_d = ram_rdata.port;
        end else begin
          if (!ram_rdata.valid && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = idx_q;
          end
          if (is_last) begin
            state_d    = StIdle;
            done_d     = 1'b1;
            old_port_d = port_q;
            if (free_found_q || !ram_rdata.valid) begin
              ram_we      = 1'b1;
              ram_waddr   = free_found_q ? free_idx_q : idx_q;
              ram_wdata   = '{valid: 1'b1, mac: mac_q, port: port_q, expiry: expiry_new};
              valid_cnt_d = valid_cnt_q + CntW'(1);
              outcome_d   = OutNew;
            end else begin
              // Drop the learn; saturate the discard count.
              if (discard_q != '1) begin
                discard_d = discard_q + SecW'(1);
              end
              outcome_d = OutFull;
            end
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StClear;
      idx_q        <= '0;
      free_found_q <= 1'b0;
      sweep_q      <= 1'b0;
      removed_q    <= '0;
      valid_cnt_q  <= '0;
      discard_q    <= '0;
      seconds_q    <= '0;
      countdown_q  <= AgingReset;
      aging_q      <= AgingReset;
      done_o       <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      free_found_q <= free_found_d;
      sweep_q      <= sweep_d;
      removed_q    <= removed_d;
      valid_cnt_q  <= valid_cnt_d;
      discard_q    <= discard_d;
      seconds_q    <= seconds_d;
      countdown_q  <= countdown_d;
      done_o       <= done_d;
      if (cfg_we_i) begin
        aging_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    free_idx_q <= free_idx_d;
    mac_q      <= mac_d;
    port_q     <= port_d;
    if (done_d) begin
      outcome_o        <= outcome_d;
      old_port_o       <= old_port_d;
      removed_count_o  <= removed_out_d;
      entries_in_use_o <= valid_cnt_d;
      discard_total_o  <= discard_d;
    end
  end

endmodule

// ===== bench/mac_learning_table_checker.sv =====
// ----------------------------------------------------------------------------
// mac_learning_table_checker: outcome predictor and scoreboard
// Watches the command, config and result channels of the learning table,
// keeps its own copy of the table, and compares every result in order.
// ----------------------------------------------------------------------------
module mac_learning_table_checker import mlt_pkg::*; #(
  parameter int unsigned NUM_ENTRIES = 1024,
  parameter int unsigned NUM_PORTS   = 64,
  parameter int unsigned CW          = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic              mode_i,
  input  logic [MacW-1:0]   mac_addr_i,
  input  logic [PortW-1:0]  port_i,
  input  logic              learning_allowed_i,
  input  logic              cfg_we_i,
  input  logic [AgingW-1:0] cfg_wdata_i,
  input  logic              done_i,
  input  logic [OutW-1:0]   outcome_i,
  input  logic [PortW-1:0]  old_port_i,
  input  logic [CW-1:0]     removed_count_i,
  input  logic [CW-1:0]     entries_in_use_i,
  input  logic [SecW-1:0]   discard_total_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [OutW-1:0]  outcome;
    logic [PortW-1:0] old_port;
    logic [CW-1:0]    removed;
    logic [CW-1:0]    in_use;
    logic [SecW-1:0]  discards;
  } learn_result_t;

  logic              tbl_valid  [NUM_ENTRIES];
  logic [MacW-1:0]   tbl_mac    [NUM_ENTRIES];
  logic [PortW-1:0]  tbl_port   [NUM_ENTRIES];
  logic [SecW-1:0]   tbl_expiry [NUM_ENTRIES];
  logic [SecW-1:0]   now_sec;
  logic [AgingW-1:0] aging, countdown;
  logic [SecW-1:0]   drops;
  int                used;
  learn_result_t     expected_q[$];

  assign pending_o = expected_q.size();

  task automatic report(string field, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    fail_count_o++;
  endtask

  function automatic learn_result_t predict_outcome(logic md, logic [MacW-1:0] mac,
                                                    logic [PortW-1:0] prt, logic ok);
    learn_result_t r;
    int            removed;
    r = '0;
    if (md == ModeTick) begin
      now_sec++;
      r.outcome = OutTick;
      if (countdown <= 1) begin
        removed = 0;
        for (int i = 0; i < NUM_ENTRIES; i++)
          if (tbl_valid[i] && tbl_expiry[i] <= now_sec) begin
            tbl_valid[i] = 1'b0;
            removed++;
          end
        used -= removed;
        r.removed = CW'(removed);
        countdown = (aging == '0) ? AgingW'(1) : aging;
        r.outcome = OutSweep;
      end else begin
        countdown--;
      end
    end else if (!ok || prt >= NUM_PORTS) begin
      r.outcome  = OutLearnOff;
      r.old_port = prt;
    end else begin
      r.outcome  = OutFull;
      r.old_port = prt;
      // hit: refresh the expiry, record a station move
      for (int i = 0; i < NUM_ENTRIES; i++)
        if (tbl_valid[i] && tbl_mac[i] == mac) begin
          r.old_port    = tbl_port[i];
          r.outcome     = (tbl_port[i] != prt) ? OutMoved : OutRefresh;
          tbl_port[i]   = prt;
          tbl_expiry[i] = now_sec + aging;
          break;
        end
      // miss: take the lowest free slot
      if (r.outcome == OutFull)
        for (int i = 0; i < NUM_ENTRIES; i++)
          if (!tbl_valid[i]) begin
            tbl_valid[i]  = 1'b1;
            tbl_mac[i]    = mac;
            tbl_port[i]   = prt;
            tbl_expiry[i] = now_sec + aging;
            used++;
            r.outcome     = OutNew;
            break;
          end
      if (r.outcome == OutFull && drops != '1) drops++;
    end
    r.in_use   = CW'(used);
    r.discards = drops;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    learn_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ENTRIES; i++) tbl_valid[i] = 1'b0;
      now_sec      = '0;
      aging        = AgingReset;
      countdown    = AgingReset;
      drops        = '0;
      used         = 0;
      fail_count_o = 0;
      expected_q.delete();
    end else begin
      if (done_i) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", outcome_i, -1);
        end else begin
          want = expected_q.pop_front();
          if (outcome_i != want.outcome) report("outcome", outcome_i, want.outcome);
          if (old_port_i != want.old_port) report("old_port", old_port_i, want.old_port);
          if (removed_count_i != want.removed)
            report("removed_count", removed_count_i, want.removed);
          if (entries_in_use_i != want.in_use)
            report("entries_in_use", entries_in_use_i, want.in_use);
          if (discard_total_i != want.discards)
            report("discard_total", discard_total_i, want.discards);
        end
      end
      if (cfg_we_i) aging = cfg_wdata_i;
      if (start_i && !busy_i)
        expected_q.push_back(predict_outcome(mode_i, mac_addr_i, port_i, learning_allowed_i));
    end
  end

endmodule

// ===== bench/mac_learning_table_with_aging_tb.sv =====
// ----------------------------------------------------------------------------
// mac_learning_table_with_aging_tb: stimulus and verdict for the MAC table
// Drives directed learns and ticks, then random phases under several aging
// times and sender gaps, plus a table fill to overflow.
// ----------------------------------------------------------------------------
module mac_learning_table_with_aging_tb import mlt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Entries   = 1024;
  localparam int unsigned CW        = $clog2(Entries + 1);
  localparam int          StallLimit = 20000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic              mode_i = ModeLearn;
  logic [MacW-1:0]   mac_addr_i = '0;
  logic [PortW-1:0]  port_i = '0;
  logic              learning_allowed_i = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [AgingW-1:0] cfg_wdata_i = '0;
  logic              done_o;
  logic [OutW-1:0]   outcome_o;
  logic [PortW-1:0]  old_port_o;
  logic [CW-1:0]     removed_count_o, entries_in_use_o;
  logic [SecW-1:0]   discard_total_o;
  int                fail_count, pending;
  int                gap_pct;
  int                stall_cycles = 0;
  logic [MacW-1:0]   station_pool[20];

  always #10 clk_i = ~clk_i;

  mac_learning_table_with_aging dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .mode_i, .mac_addr_i, .port_i,
    .learning_allowed_i, .cfg_we_i, .cfg_wdata_i, .done_o, .outcome_o,
    .old_port_o, .removed_count_o, .entries_in_use_o, .discard_total_o
  );

  mac_learning_table_checker #(.NUM_ENTRIES(Entries), .CW(CW)) u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .mode_i, .mac_addr_i, .port_i,
    .learning_allowed_i, .cfg_we_i, .cfg_wdata_i, .done_i(done_o), .outcome_i(outcome_o),
    .old_port_i(old_port_o), .removed_count_i(removed_count_o),
    .entries_in_use_i(entries_in_use_o), .discard_total_i(discard_total_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [MacW-1:0] rand_mac();
    return MacW'({$urandom, $urandom});
  endfunction

  // Present one transaction and hold it until the block takes it.
  // Entered and left just after a rising edge.
  task automatic issue(logic md, logic [MacW-1:0] mac, logic [PortW-1:0] prt, logic ok);
    int gap;
    gap = 0;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i            <= 1'b1;
    mode_i             <= md;
    mac_addr_i         <= mac;
    port_i             <= prt;
    learning_allowed_i <= ok;
    // busy is stable at the falling edge; the next rising edge accepts
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic tick();
    issue(ModeTick, rand_mac(), 6'($urandom), 1'($urandom));
  endtask

  // Drain all outstanding results, then write the aging time.
  task automatic set_aging(logic [AgingW-1:0] secs);
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= secs;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= ~secs;
  endtask

  task automatic random_mix(int count);
    int k;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(99);
      if (k < 25) tick();
      else if (k < 80) issue(ModeLearn, station_pool[$urandom_range(19)], 6'($urandom),
                             $urandom_range(9) != 0);
      else issue(ModeLearn, rand_mac(), 6'($urandom), $urandom_range(9) != 0);
    end
  endtask

  initial begin
    logic [AgingW-1:0] aging_plan[8];
    aging_plan = '{20'd0, 20'd1, 20'd2, 20'd7, 20'd300, 20'hFFFFF, 20'd1000000, 20'd1};
    for (int i = 0; i < 20; i++) station_pool[i] = rand_mac();
    station_pool[0] = '0;
    station_pool[1] = '1;
    gap_pct = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: new, refresh, move, learning off, extreme MACs and ports.
    issue(ModeLearn, '0, 6'd0, 1'b1);
    issue(ModeLearn, '1, 6'd63, 1'b1);
    issue(ModeLearn, '0, 6'd0, 1'b1);
    issue(ModeLearn, '0, 6'd63, 1'b1);
    issue(ModeLearn, '1, 6'd0, 1'b1);
    issue(ModeLearn, 48'hAAAA_AAAA_AAAA, 6'd21, 1'b0);
    issue(ModeLearn, 48'h5555_5555_5555, 6'd42, 1'b1);
    issue(ModeLearn, 48'h5555_5555_5555, 6'd42, 1'b0);
    issue(ModeLearn, 48'h5555_5555_5555, 6'd42, 1'b1);
    issue(ModeTick, '1, '1, 1'b1);
    issue(ModeTick, '0, '0, 1'b0);
    repeat (4) tick();

    // Random phases: cycle the aging time and the sender gap rate.
    for (int p = 0; p < 8; p++) begin
      set_aging(aging_plan[p]);
      gap_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 59 : 8;
      random_mix(p == 0 ? 120 : 55);
    end

    // Fill: overflow the table with fresh MACs, then tick; a sweep runs
    // only if the aging countdown has run out by then.
    set_aging(20'd3);
    gap_pct = 0;
    for (int n = 0; n < Entries + 8; n++) issue(ModeLearn, rand_mac(), 6'($urandom), 1'b1);
    repeat (8) tick();
    gap_pct = 59;
    random_mix(40);

    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
